>>> rtl/bcdasc_pkg.sv
`timescale 1ns / 1ps

package bcdasc_pkg;

   // Digit count, legal range 1..16.
   localparam int Digits   = 16;
   localparam int DataW    = 64;
   localparam int ModeW    = 2;
   localparam int FlagW    = 7;
   // Carry chain is split over two stages at this digit.
   localparam int HalfDig  = (Digits + 1) / 2;

   localparam logic [ModeW-1:0] ModeAdd = 2'd0;
   localparam logic [ModeW-1:0] ModeSub = 2'd1;
   localparam logic [ModeW-1:0] ModeCmp = 2'd2;

   localparam logic [4:0] DigitMax   = 5'd9;
   localparam logic [4:0] DigitRadix = 5'd10;

   typedef logic [Digits-1:0][3:0] digits_type;

   typedef struct packed {
      logic [ModeW-1:0]  op;
      digits_type        a_dig;
      digits_type        b_dig;
      logic [Digits-1:0] gen;      // digit generates a carry / borrow
      logic [Digits-1:0] prop;     // digit passes an incoming carry / borrow
      logic [Digits-1:0] lt_vec;
      logic [Digits-1:0] gt_vec;
      logic [Digits:0]   carry;    // carry[i] flows into digit i
      logic              lt;
      logic              gt;
      logic              bad;
      logic              zero;
   } pipe_type;

   typedef struct packed {
      logic             bad;
      logic             zero;
      logic             gt;
      logic             eq;
      logic             lt;
      logic             serr;
      logic             ovf;
   } flags_type;

   typedef struct packed {
      logic [DataW-1:0] result;
      flags_type        flags;
   } rsp_type;

endpackage

>>> rtl/bcdasc_prep.sv
`timescale 1ns / 1ps

// Stage 1: per-digit checks, compares and carry generate/propagate terms.
module bcdasc_prep (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  logic                                valid_in_port,
   input  logic [bcdasc_pkg::ModeW-1:0]        mode,
   input  logic [bcdasc_pkg::DataW-1:0]        operand_a,
   input  logic [bcdasc_pkg::DataW-1:0]        operand_b,
   output logic                                valid_out,
   output bcdasc_pkg::pipe_type                data_out
);

   logic                 valid_ff;
   bcdasc_pkg::pipe_type data_ff;
   bcdasc_pkg::pipe_type data_in;

   always_comb begin
      logic [3:0] x;
      logic [3:0] y;
      logic [4:0] s;
      logic       sub;
      data_in = '0;
      if (mode == bcdasc_pkg::ModeAdd) begin
         data_in.op = bcdasc_pkg::ModeAdd;
      end else if (mode == bcdasc_pkg::ModeSub) begin
         data_in.op = bcdasc_pkg::ModeSub;
      end else begin
         data_in.op = bcdasc_pkg::ModeCmp;
      end
      sub = (mode == bcdasc_pkg::ModeSub);
      data_in.zero = 1'b1;
      for (int i = 0; i < bcdasc_pkg::Digits; i++) begin
         x = operand_a[4*i +: 4];
         y = operand_b[4*i +: 4];
         s = {1'b0, x} + {1'b0, y};
         data_in.a_dig[i]  = x;
         data_in.b_dig[i]  = y;
         data_in.lt_vec[i] = (x < y);
         data_in.gt_vec[i] = (x > y);
         if (sub) begin
            data_in.gen[i]  = (x < y);
            data_in.prop[i] = (x == y);
         end else begin
            data_in.gen[i]  = (s > bcdasc_pkg::DigitMax);
            data_in.prop[i] = (s == bcdasc_pkg::DigitMax);
         end
         if (({1'b0, x} > bcdasc_pkg::DigitMax) || ({1'b0, y} > bcdasc_pkg::DigitMax)) begin
            data_in.bad = 1'b1;
         end
         if (x != 4'd0) begin
            data_in.zero = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in_port;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

>>> rtl/bcdasc_carry_lo.sv
`timescale 1ns / 1ps

// Stage 2: carry chain over the lower digits, magnitude compare.
module bcdasc_carry_lo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic                 valid_in_port,
   input  bcdasc_pkg::pipe_type data_in_port,
   output logic                 valid_out,
   output bcdasc_pkg::pipe_type data_out
);

   logic                 valid_ff;
   bcdasc_pkg::pipe_type data_ff;
   bcdasc_pkg::pipe_type data_in;

   always_comb begin
      data_in = data_in_port;
      // lt and gt digit masks are disjoint: the top differing digit wins
      data_in.lt = (data_in_port.lt_vec > data_in_port.gt_vec);
      data_in.gt = (data_in_port.gt_vec > data_in_port.lt_vec);
      data_in.carry[0] = 1'b0;
      for (int i = 0; i < bcdasc_pkg::HalfDig; i++) begin
         data_in.carry[i+1] = data_in_port.gen[i]
                            | (data_in_port.prop[i] & data_in.carry[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in_port;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

>>> rtl/bcdasc_carry_hi.sv
`timescale 1ns / 1ps

// Stage 3: carry chain over the upper digits.
module bcdasc_carry_hi (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic                 valid_in_port,
   input  bcdasc_pkg::pipe_type data_in_port,
   output logic                 valid_out,
   output bcdasc_pkg::pipe_type data_out
);

   logic                 valid_ff;
   bcdasc_pkg::pipe_type data_ff;
   bcdasc_pkg::pipe_type data_in;

   always_comb begin
      data_in = data_in_port;
      for (int i = bcdasc_pkg::HalfDig; i < bcdasc_pkg::Digits; i++) begin
         data_in.carry[i+1] = data_in_port.gen[i]
                            | (data_in_port.prop[i] & data_in.carry[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in_port;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

>>> rtl/bcdasc_result.sv
`timescale 1ns / 1ps

// Stage 4: digit sums / differences with decimal correction, result mux,
// output register.
module bcdasc_result (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  logic                 valid_in_port,
   input  bcdasc_pkg::pipe_type data_in_port,
   output logic                 valid_out,
   output bcdasc_pkg::rsp_type  data_out
);

   logic                valid_ff;
   bcdasc_pkg::rsp_type data_ff;
   bcdasc_pkg::rsp_type data_in;

   always_comb begin
      logic [4:0]                   s;
      logic [4:0]                   r;
      logic [bcdasc_pkg::DataW-1:0] sum;
      logic [bcdasc_pkg::DataW-1:0] diff;
      logic                         is_add;
      logic                         is_sub;
      sum  = '0;
      diff = '0;
      for (int i = 0; i < bcdasc_pkg::Digits; i++) begin
         s = {1'b0, data_in_port.a_dig[i]} + {1'b0, data_in_port.b_dig[i]}
           + {4'd0, data_in_port.carry[i]};
         if (s > bcdasc_pkg::DigitMax) begin
            s = s - bcdasc_pkg::DigitRadix;
         end
         r = {1'b0, data_in_port.a_dig[i]} + bcdasc_pkg::DigitRadix
           - {1'b0, data_in_port.b_dig[i]} - {4'd0, data_in_port.carry[i]};
         if (r > bcdasc_pkg::DigitMax) begin
            r = r - bcdasc_pkg::DigitRadix;
         end
         sum[4*i +: 4]  = s[3:0];
         diff[4*i +: 4] = r[3:0];
      end
      is_add = !data_in_port.bad && (data_in_port.op == bcdasc_pkg::ModeAdd);
      is_sub = !data_in_port.bad && (data_in_port.op == bcdasc_pkg::ModeSub);

      data_in.result     = '0;
      if (is_add) begin
         data_in.result = sum;
      end else if (is_sub && !data_in_port.lt) begin
         data_in.result = diff;
      end
      data_in.flags.ovf  = is_add && data_in_port.carry[bcdasc_pkg::Digits];
      data_in.flags.serr = is_sub && data_in_port.lt;
      data_in.flags.lt   = data_in_port.lt;
      data_in.flags.eq   = !data_in_port.lt && !data_in_port.gt;
      data_in.flags.gt   = data_in_port.gt;
      data_in.flags.zero = data_in_port.zero;
      data_in.flags.bad  = data_in_port.bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in_port;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

>>> rtl/bcd_add_subtract_compare.sv
`timescale 1ns / 1ps
// Packed-BCD add / subtract / compare, four register stages.
// Registers in order: prep, lower carry chain, upper carry chain, correction +
// output register. Throughput: one transfer per cycle unless a stalled output
// fills all stages; each stage advances when it is empty or the stage after it
// moves, so bubbles are squeezed out under a stalled output.
// Reset: synchronous, clears all stage valid bits; data registers are not reset.
module bcd_add_subtract_compare (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [2*bcdasc_pkg::DataW-1:0]    req_tdata,  // operand_a, operand_b
   input  logic [bcdasc_pkg::ModeW-1:0]      req_tuser,  // mode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bcdasc_pkg::DataW-1:0]      rsp_tdata,  // result_value
   // carry_overflow, subtract_error, a_less, a_equal, a_greater, a_is_zero,
   // invalid_digit
   output logic [bcdasc_pkg::FlagW-1:0]      rsp_tuser
);

   logic                 v1, v2, v3, v4;
   logic                 go1, go2, go3, go4;
   bcdasc_pkg::pipe_type d1, d2, d3;
   bcdasc_pkg::rsp_type  d4;

   assign go4 = !v4 || rsp_tready;
   assign go3 = !v3 || go4;
   assign go2 = !v2 || go3;
   assign go1 = !v1 || go2;

   assign req_tready = go1;

   bcdasc_prep u_prep (
      .clock         (clock),
      .reset         (reset),
      .load          (go1),
      .valid_in_port (req_tvalid),
      .mode          (req_tuser),
      .operand_a     (req_tdata[bcdasc_pkg::DataW-1:0]),
      .operand_b     (req_tdata[2*bcdasc_pkg::DataW-1:bcdasc_pkg::DataW]),
      .valid_out     (v1),
      .data_out      (d1)
   );

   bcdasc_carry_lo u_carry_lo (
      .clock         (clock),
      .reset         (reset),
      .load          (go2),
      .valid_in_port (v1),
      .data_in_port  (d1),
      .valid_out     (v2),
      .data_out      (d2)
   );

   bcdasc_carry_hi u_carry_hi (
      .clock         (clock),
      .reset         (reset),
      .load          (go3),
      .valid_in_port (v2),
      .data_in_port  (d2),
      .valid_out     (v3),
      .data_out      (d3)
   );

   bcdasc_result u_result (
      .clock         (clock),
      .reset         (reset),
      .load          (go4),
      .valid_in_port (v3),
      .data_in_port  (d3),
      .valid_out     (v4),
      .data_out      (d4)
   );

   assign rsp_tvalid = v4;
   assign rsp_tdata  = d4.result;
   assign rsp_tuser  = d4.flags;

   // exactly one ordering flag per result
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot({d4.flags.lt, d4.flags.eq, d4.flags.gt}))
      else $error("compare flags not one-hot");

   // bad digits force a zero result and no arithmetic flags
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && d4.flags.bad) |->
         (rsp_tdata == '0 && !d4.flags.ovf && !d4.flags.serr))
      else $error("invalid digit did not clear result");

   // refused subtract always reports a < b and a zero result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && d4.flags.serr) |->
         (d4.flags.lt && !d4.flags.ovf && rsp_tdata == '0))
      else $error("subtract error inconsistent");

   // an accepted item must show up in stage one on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v1)
      else $error("accepted transfer lost at stage one");

endmodule
